// ===== hw/rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// KMP matcher package
// Shared constants for the substring matcher: request kinds and sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

   // Default capacity of the pattern store, in bytes.
   localparam int PATTERN_MAX_DEFAULT = 16;

   // Width of one pattern or text symbol.
   localparam int SYMBOL_W = 8;

   // Request kinds carried on the request channel's tuser.
   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

endpackage : kmp_pkg

`default_nettype wire

// ===== hw/rtl/kmp_substring_matcher_top.sv =====
// ----------------------------------------------------------------------------
// KMP substring matcher
// Loads a pattern, builds its prefix-failure table and searches text streams.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload                                Transfer
// req_*     in         tdata: symbol; tuser: kind; tlast      tvalid & tready
// rsp_*     out        tdata[0]: found; tdata[7:1]: zero      tvalid & tready
//
// A pattern request is absorbed in its accept cycle. Closing a pattern builds
// the failure table with one shared compare unit over the two-port pattern
// memory: a start step, a read and a compare per scan step, a fallback step
// and a new read and compare per fallback, and a closing step. A text request
// passes from its accept through start, read and compare, and through a
// fallback, read and compare again for every fallback through the failure
// table; once the pattern has been found a text request goes from start
// straight back to idle. Each fallback undoes an earlier advance of the
// match position. The final text request of a text then moves its result
// into the response register in an emit state, and waits there while that
// register still holds an unaccepted result. Reset is synchronous and active
// high and clears all control state; the memories hold garbage until written.
// While a result waits on a stalled response channel the block keeps taking
// pattern and text requests, and only stalls when a second result is ready.
//
`default_nettype none

module kmp_substring_matcher_top
   import kmp_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Request channel.
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [SYMBOL_W-1:0] req_tdata,   // [7:0] symbol
   input  wire logic                req_tuser,   // [0] operation: pattern or text
   input  wire logic                req_tlast,   // last byte of pattern or text
   // Response channel.
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata    // [0] found, [7:1] zero
);

   // Address width of the stores and width of lengths and counters that can
   // hold the full capacity.
   localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LW = $clog2(PATTERN_MAX + 1);

   localparam logic [LW-1:0] LEN_MAX = LW'(PATTERN_MAX);
   localparam logic [LW-1:0] LEN_ONE = LW'(1);
   localparam logic [AW-1:0] POS_ONE = AW'(1);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_B_START = 4'd1;
   localparam logic [3:0] ST_B_READ  = 4'd2;
   localparam logic [3:0] ST_B_CMP   = 4'd3;
   localparam logic [3:0] ST_B_FALL  = 4'd4;
   localparam logic [3:0] ST_S_START = 4'd5;
   localparam logic [3:0] ST_S_READ  = 4'd6;
   localparam logic [3:0] ST_S_CMP   = 4'd7;
   localparam logic [3:0] ST_S_FALL  = 4'd8;
   localparam logic [3:0] ST_EMIT    = 4'd9;

   // Control state.
   logic [3:0]          state_ff, state_in;
   logic [LW-1:0]       len_ff, len_in;
   logic [AW-1:0]       match_ff, match_in;
   logic                found_ff, found_in;
   logic                open_ff, open_in;
   logic                text_pend_ff, text_pend_in;
   logic [LW-1:0]       i_ff, i_in;
   logic [AW-1:0]       k_ff, k_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload held for the text request being worked on, and the result.
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic                last_ff, last_in;
   logic                rsp_found_ff, rsp_found_in;

   // Pattern memory: one write port, two registered read ports.
   logic [SYMBOL_W-1:0] pat_mem [PATTERN_MAX];
   logic                pat_we;
   logic [AW-1:0]       pat_waddr;
   logic [AW-1:0]       pat_raddr_a;
   logic [SYMBOL_W-1:0] pat_rd_a_ff;
   logic [SYMBOL_W-1:0] pat_rd_b_ff;

   // Failure table: one write port, one registered read port.
   logic [AW-1:0]       ft_mem [PATTERN_MAX];
   logic                ft_we;
   logic [AW-1:0]       ft_waddr;
   logic [AW-1:0]       ft_wdata;
   logic [AW-1:0]       ft_raddr;
   logic [AW-1:0]       ft_rd_ff;

   // Shared compare unit and its helpers.
   logic [SYMBOL_W-1:0] cmp_lhs;
   logic                cmp_eq;
   logic                req_fire;
   logic [LW-1:0]       len_base;
   logic [LW-1:0]       match_next;
   logic                emit_go;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_found_ff};

   // The compare unit sees the pattern byte at i (build) or at the match
   // position (search) on port A; the other operand is the byte at k or
   // the held text symbol.
   assign cmp_lhs = (state_ff == ST_B_CMP) ? pat_rd_b_ff : sym_ff;
   assign cmp_eq  = (pat_rd_a_ff == cmp_lhs);

   assign pat_raddr_a = (state_ff == ST_S_READ) ? match_ff : i_ff[AW-1:0];
   assign ft_raddr    = (state_ff == ST_S_CMP) ? (match_ff - POS_ONE)
                                               : (k_ff - POS_ONE);

   assign len_base   = open_ff ? len_ff : '0;
   assign match_next = LW'(match_ff) + (cmp_eq ? LEN_ONE : '0);
   assign emit_go    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      match_in     = match_ff;
      found_in     = found_ff;
      open_in      = open_ff;
      text_pend_in = text_pend_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      rsp_found_in = rsp_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pat_we       = 1'b0;
      pat_waddr    = len_base[AW-1:0];
      ft_we        = 1'b0;
      ft_waddr     = i_ff[AW-1:0];
      ft_wdata     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_PATTERN) begin
                  // A pattern byte opens a new pattern if none is open,
                  // and bytes past the capacity are dropped.
                  open_in  = 1'b1;
                  len_in   = len_base;
                  match_in = '0;
                  found_in = 1'b0;
                  if (len_base < LEN_MAX) begin
                     pat_we = 1'b1;
                     len_in = len_base + LEN_ONE;
                  end
                  if (req_tlast) begin
                     text_pend_in = 1'b0;
                     state_in     = ST_B_START;
                  end
               end else begin
                  sym_in       = req_tdata;
                  last_in      = req_tlast;
                  text_pend_in = 1'b1;
                  // Text arriving on an open pattern closes it first.
                  state_in     = open_ff ? ST_B_START : ST_S_START;
               end
            end
         end

         ST_B_START: begin
            if (len_ff == '0) begin
               open_in  = 1'b0;
               match_in = '0;
               found_in = 1'b0;
               state_in = text_pend_ff ? ST_S_START : ST_IDLE;
            end else begin
               ft_we    = 1'b1;
               ft_waddr = '0;
               ft_wdata = '0;
               i_in     = LEN_ONE;
               k_in     = '0;
               state_in = ST_B_READ;
            end
         end

         ST_B_READ: begin
            if (i_ff >= len_ff) begin
               open_in  = 1'b0;
               match_in = '0;
               found_in = 1'b0;
               state_in = text_pend_ff ? ST_S_START : ST_IDLE;
            end else begin
               state_in = ST_B_CMP;
            end
         end

         ST_B_CMP: begin
            if (cmp_eq) begin
               ft_we    = 1'b1;
               ft_wdata = k_ff + POS_ONE;
               k_in     = k_ff + POS_ONE;
               i_in     = i_ff + LEN_ONE;
               state_in = ST_B_READ;
            end else if (k_ff != '0) begin
               state_in = ST_B_FALL;
            end else begin
               ft_we    = 1'b1;
               ft_wdata = '0;
               i_in     = i_ff + LEN_ONE;
               state_in = ST_B_READ;
            end
         end

         ST_B_FALL: begin
            k_in     = ft_rd_ff;
            state_in = ST_B_READ;
         end

         ST_S_START: begin
            text_pend_in = 1'b0;
            if (found_ff) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end else if (len_ff == '0) begin
               // An empty pattern is found in every text.
               found_in = 1'b1;
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end else begin
               if (LW'(match_ff) >= len_ff) begin
                  match_in = '0;
               end
               state_in = ST_S_READ;
            end
         end

         ST_S_READ: begin
            state_in = ST_S_CMP;
         end

         ST_S_CMP: begin
            if (match_ff != '0 && !cmp_eq) begin
               state_in = ST_S_FALL;
            end else begin
               if (match_next >= len_ff) begin
                  found_in = 1'b1;
                  match_in = '0;
               end else begin
                  match_in = match_next[AW-1:0];
               end
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end

         ST_S_FALL: begin
            match_in = ft_rd_ff;
            state_in = ST_S_READ;
         end

         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               found_in     = 1'b0;
               match_in     = '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         match_ff     <= '0;
         found_ff     <= 1'b0;
         open_ff      <= 1'b0;
         text_pend_ff <= 1'b0;
         i_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         match_ff     <= match_in;
         found_ff     <= found_in;
         open_ff      <= open_in;
         text_pend_ff <= text_pend_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      last_ff      <= last_in;
      rsp_found_ff <= rsp_found_in;
   end

   // Pattern memory.
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_waddr] <= req_tdata;
      end
      pat_rd_a_ff <= pat_mem[pat_raddr_a];
      pat_rd_b_ff <= pat_mem[k_ff];
   end

   // Failure table memory.
   always_ff @(posedge clock) begin
      if (ft_we) begin
         ft_mem[ft_waddr] <= ft_wdata;
      end
      ft_rd_ff <= ft_mem[ft_raddr];
   end

   // The match position always stays below a nonzero pattern length.
   a_match_below_len: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> (LW'(match_ff) < len_ff))
      else $error("match position reached the pattern length");

   // While building, the prefix length trails the scan index.
   a_k_below_i: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_CMP) |-> (LW'(k_ff) < i_ff))
      else $error("failure build prefix length not below scan index");

   // The stored pattern never exceeds the capacity.
   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("pattern length above capacity");

   // A delivered result leaves a fresh search state and a valid response.
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (rsp_valid_ff && !found_ff && match_ff == '0))
      else $error("result hand-off did not reset the search state");

endmodule : kmp_substring_matcher_top

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// KMP substring matcher testbench
// Drives pattern and text requests into the matcher and checks every found
// flag against a cycle-free software copy of the search, kept in step with
// the requests as they are accepted. A short table of directed requests
// comes first, then random patterns and texts with idle bursts on both
// channels, one long response stall and pauses that let the block drain.
// ----------------------------------------------------------------------------

module tb_top;
   import kmp_pkg::*;

   localparam int PATTERN_MAX   = PATTERN_MAX_DEFAULT;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int QUIET_ITEMS   = 250;
   localparam int LONG_STALL    = 300;
   localparam int DRAIN_CYCLES  = 60;
   localparam int TIMEOUT_NS    = 5_000_000;
   localparam int DIRECTED_N    = 17;

   // One row of the directed table. Where pinned is set the found flag is
   // taken from the row instead of from the predictor.
   typedef struct packed {
      logic                kind;
      logic [SYMBOL_W-1:0] symbol;
      logic                is_last;
      logic                pinned;
      logic                pinned_found;
   } directed_row_type;

   localparam directed_row_type DIRECTED [DIRECTED_N] = '{
      // An empty pattern after reset is found in any text.
      '{OP_TEXT,    8'h00, 1'b1, 1'b1, 1'b1},
      // Two-byte pattern with both extreme byte values.
      '{OP_PATTERN, 8'h00, 1'b0, 1'b0, 1'b0},
      '{OP_PATTERN, 8'hFF, 1'b1, 1'b0, 1'b0},
      '{OP_TEXT,    8'h00, 1'b0, 1'b0, 1'b0},
      '{OP_TEXT,    8'hFF, 1'b1, 1'b1, 1'b1},
      '{OP_TEXT,    8'hFF, 1'b1, 1'b1, 1'b0},
      // A repeated prefix forces a fallback through the failure table.
      '{OP_PATTERN, 8'h41, 1'b0, 1'b0, 1'b0},
      '{OP_PATTERN, 8'h41, 1'b0, 1'b0, 1'b0},
      '{OP_PATTERN, 8'h42, 1'b1, 1'b0, 1'b0},
      '{OP_TEXT,    8'h41, 1'b0, 1'b0, 1'b0},
      '{OP_TEXT,    8'h41, 1'b0, 1'b0, 1'b0},
      '{OP_TEXT,    8'h41, 1'b0, 1'b0, 1'b0},
      '{OP_TEXT,    8'h42, 1'b1, 1'b0, 1'b0},
      // A pattern left open is closed by the first text request.
      '{OP_PATTERN, 8'h78, 1'b0, 1'b0, 1'b0},
      '{OP_TEXT,    8'h78, 1'b1, 1'b1, 1'b1},
      // Bytes after a complete match do not clear the found flag.
      '{OP_TEXT,    8'h78, 1'b0, 1'b0, 1'b0},
      '{OP_TEXT,    8'h00, 1'b1, 1'b1, 1'b1}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SYMBOL_W-1:0] req_tdata = '0;   // [7:0] symbol
   logic                req_tuser = 1'b0; // [0] operation: pattern or text
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;        // [0] found, [7:1] zero

   kmp_substring_matcher_top #(.PATTERN_MAX(PATTERN_MAX)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Predicted matcher state. The store and the table are only ever read
   // below the stored pattern length, so their contents at reset do not
   // matter.
   logic [SYMBOL_W-1:0] pat_mem  [PATTERN_MAX];
   logic [4:0]          fail_tab [PATTERN_MAX];
   logic [4:0]          pat_len   = '0;
   logic [4:0]          match_pos = '0;
   logic                hit_flag  = 1'b0;
   logic                pat_open  = 1'b0;

   // Found flags still owed by the block, oldest first.
   logic found_expected_q [$];

   int  sent_count     = 0;
   int  mismatch_count = 0;
   int  req_idle_pct   = 0;
   int  rsp_idle_pct   = 0;
   bit  quiet_tail     = 1'b0;
   bit  long_stall_request = 1'b0;
   bit  long_stall_over    = 1'b0;
   logic exp_found;

   // Closing a pattern builds the prefix-failure table: entry i holds the
   // length of the longest proper prefix that is also a suffix of bytes 0..i.
   function automatic void close_pattern();
      int i;
      int k;
      if (pat_len != 0) begin
         fail_tab[0] = '0;
         i = 1;
         k = 0;
         while (i < pat_len) begin
            if (pat_mem[i] == pat_mem[k]) begin
               k++;
               fail_tab[i] = 5'(k);
               i++;
            end else if (k != 0) begin
               k = fail_tab[k-1];
            end else begin
               fail_tab[i] = '0;
               i++;
            end
         end
      end
      pat_open  = 1'b0;
      match_pos = '0;
      hit_flag  = 1'b0;
   endfunction

   // Advances the predicted state by one accepted request and tells whether
   // it yields a result and what that result's found flag is.
   function automatic void predict_match(input logic kind, input logic [SYMBOL_W-1:0] sym,
                                         input logic is_last, output bit has_result,
                                         output logic found);
      logic [4:0] j;
      has_result = 1'b0;
      found      = 1'b0;
      if (kind == OP_PATTERN) begin
         if (!pat_open) begin
            pat_len  = '0;
            pat_open = 1'b1;
         end
         // Bytes beyond the store's capacity are dropped.
         if (pat_len < PATTERN_MAX) begin
            pat_mem[pat_len[3:0]] = sym;
            pat_len++;
         end
         match_pos = '0;
         hit_flag  = 1'b0;
         if (is_last)
            close_pattern();
         return;
      end
      if (pat_open)
         close_pattern();
      if (!hit_flag) begin
         if (pat_len == 0) begin
            hit_flag = 1'b1;
         end else begin
            j = match_pos;
            if (j >= pat_len)
               j = '0;
            while (j != 0 && sym != pat_mem[j[3:0]])
               j = fail_tab[4'(j - 5'd1)];
            if (sym == pat_mem[j[3:0]])
               j++;
            if (j >= pat_len) begin
               hit_flag = 1'b1;
               j = '0;
            end
            match_pos = j;
         end
      end
      if (is_last) begin
         has_result = 1'b1;
         found      = hit_flag;
         match_pos  = '0;
         hit_flag   = 1'b0;
      end
   endfunction

   // Offers one request, optionally after an idle burst, and waits until it
   // is taken. The expectation is recorded at the accepting edge.
   task automatic send_request(input logic kind, input logic [SYMBOL_W-1:0] sym,
                               input logic is_last, input logic pinned,
                               input logic pinned_found);
      bit   has_result;
      logic found;
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= sym;
      req_tlast  <= is_last;
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      predict_match(kind, sym, is_last, has_result, found);
      if (has_result)
         found_expected_q.push_back(pinned ? pinned_found : found);
      sent_count++;
   endtask

   // Holds the request channel idle until every owed result has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (found_expected_q.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("tb_top: mismatch at %0t: %s", $realtime, what);
   endtask

   // Response checker: every accepted result is compared with the oldest
   // owed found flag; the padding bits above it must read as zero.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (found_expected_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result, tdata %02h", rsp_tdata));
         end else begin
            exp_found = found_expected_q.pop_front();
            if (rsp_tdata[0] !== exp_found || rsp_tdata[7:1] !== 7'd0)
               note_mismatch($sformatf("found expected %0b, tdata actual %02h",
                                       exp_found, rsp_tdata));
         end
      end
   end

   // Response side: random ready bursts, one long hold-off on request of the
   // stimulus, and a steady ready once the quiet tail of the run begins.
   initial begin
      bit stall_taken;
      stall_taken = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (long_stall_request && !stall_taken) begin
            stall_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            long_stall_over = 1'b1;
         end else if (!quiet_tail && rsp_idle_pct != 0 &&
                      $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // A small alphabet makes matches and fallbacks common; one byte in ten is
   // drawn from the whole range so that every symbol bit toggles.
   logic [SYMBOL_W-1:0] alphabet [3];
   int                  alphabet_n = 1;

   function automatic logic [SYMBOL_W-1:0] pick_symbol();
      if ($urandom_range(0, 9) == 0)
         return SYMBOL_W'($urandom_range(0, 255));
      return alphabet[$urandom_range(0, alphabet_n - 1)];
   endfunction

   // Main stimulus.
   initial begin
      logic [SYMBOL_W-1:0] cur_pat [20];
      logic [SYMBOL_W-1:0] sym;
      int  cur_len;
      int  plen;
      int  ntexts;
      int  tlen;
      int  embed_at;
      bit  open_pat;
      bit  cut_text;
      bit  long_stall_done;
      bit  forced_drain_done;
      bit  drain_ok;

      cur_len           = 0;
      long_stall_done   = 1'b0;
      forced_drain_done = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, without idling.
      for (int r = 0; r < DIRECTED_N; r++)
         send_request(DIRECTED[r].kind, DIRECTED[r].symbol, DIRECTED[r].is_last,
                      DIRECTED[r].pinned, DIRECTED[r].pinned_found);
      wait_for_drain();

      sent_count = 0;
      while (sent_count < RANDOM_ITEMS) begin
         if (sent_count >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet_tail = 1'b1;
         case ($urandom_range(0, 2))
            0: req_idle_pct = 0;
            1: req_idle_pct = 10;
            default: req_idle_pct = 35;
         endcase
         case ($urandom_range(0, 2))
            0: rsp_idle_pct = 0;
            1: rsp_idle_pct = 15;
            default: rsp_idle_pct = 40;
         endcase
         if (quiet_tail)
            req_idle_pct = 0;

         // One long response stall while requests keep coming, so the block
         // fills up and pushes back on the request channel.
         if (!long_stall_done && sent_count >= 500) begin
            long_stall_request = 1'b1;
            long_stall_done    = 1'b1;
         end
         // Now and then the sender waits for every owed result, but never
         // during the long stall and never in the quiet tail.
         drain_ok = !quiet_tail && (!long_stall_done || long_stall_over);
         if (drain_ok &&
             ($urandom_range(0, 5) == 0 || (!forced_drain_done && sent_count >= 800))) begin
            forced_drain_done = 1'b1;
            wait_for_drain();
         end

         alphabet_n = $urandom_range(1, 3);
         for (int a = 0; a < 3; a++)
            alphabet[a] = SYMBOL_W'($urandom_range(0, 255));

         // Mostly a fresh pattern; sometimes a long one that may overflow the store,
         // and sometimes one left open for the text to close.
         if ($urandom_range(0, 19) != 0) begin
            plen     = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
                                                   : $urandom_range(1, 6);
            open_pat = ($urandom_range(0, 9) == 0);
            for (int p = 0; p < plen; p++) begin
               sym        = pick_symbol();
               cur_pat[p] = sym;
               send_request(OP_PATTERN, sym, (p == plen - 1) && !open_pat, 1'b0, 1'b0);
            end
            cur_len = plen;
         end

         // Several texts under the same pattern. About half of those long enough
         // carry the pattern at a random place; a few are cut off without a last
         // byte, so the next text or pattern arrives in the middle of a text.
         ntexts = $urandom_range(1, 4);
         for (int t = 0; t < ntexts; t++) begin
            tlen     = $urandom_range(1, 24);
            embed_at = -1;
            if (cur_len != 0 && tlen >= cur_len && $urandom_range(0, 1) == 1)
               embed_at = $urandom_range(0, tlen - cur_len);
            cut_text = ($urandom_range(0, 11) == 0);
            for (int b = 0; b < tlen; b++) begin
               if (embed_at >= 0 && b >= embed_at && b < embed_at + cur_len)
                  sym = cur_pat[b - embed_at];
               else
                  sym = pick_symbol();
               send_request(OP_TEXT, sym, (b == tlen - 1) && !cut_text, 1'b0, 1'b0);
            end
         end
      end

      // Wait for every owed result, then a while longer so that a stray
      // late result would still be caught.
      req_tvalid <= 1'b0;
      while (found_expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && found_expected_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("tb_top: FAIL");
      $finish;
   end

endmodule : tb_top

// ===== files.f =====
hw/rtl/kmp_pkg.sv
hw/rtl/kmp_substring_matcher_top.sv
tb/tb_top.sv
